[rtl/itda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: shared package
// Character codes and the handoff record between the converter and the
// character emitter.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Width of the raw value field on the input stream.
  localparam int unsigned ValueFieldBits = 32;
  // Width of one output character.
  localparam int unsigned CharBits = 8;

  // ASCII codes used in the text.
  localparam logic [CharBits-1:0] CharZero  = 8'h30;
  localparam logic [CharBits-1:0] CharMinus = 8'h2D;

  // Handoff from the converter: the BCD digits are ready, with the sign flag.
  typedef struct packed {
    logic valid;
    logic neg;
  } itda_conv_t;

endpackage

[rtl/itda_dabble.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: bit-serial binary to BCD converter
// Takes the magnitude of the input word and shifts it one bit per cycle into
// a BCD register, adding three to every digit of five or more before each
// shift (double dabble).
// ----------------------------------------------------------------------------
module itda_dabble #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Start request with the raw word and the mode flag
  input  logic                    start_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  input  logic                    signed_mode_i,
  output logic                    ready_o,
  // Digits and handoff toward the emitter
  output logic [4*NUM_DIGITS-1:0] bcd_o,
  output itda_pkg::itda_conv_t    conv_o,
  input  logic                    take_i
);
  import itda_pkg::*;

  localparam int unsigned CntBits = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dab_state_e;

  dab_state_e                state_q, state_d;
  logic [CntBits-1:0]        cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic [VALUE_BITS-1:0]     sr_q, sr_d;
  logic [4*NUM_DIGITS-1:0]   bcd_q, bcd_d;
  logic [4*NUM_DIGITS-1:0]   bcd_adj;
  logic                      neg_in;

  // Sign of the incoming word in signed mode.
  assign neg_in = signed_mode_i & value_i[VALUE_BITS-1];

  // Add three to every digit that would reach ten or more after the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Sequencer: load, one bit per cycle, then hold until the emitter takes it.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    sr_d    = sr_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          neg_d   = neg_in;
          sr_d    = neg_in ? (~value_i + 1'b1) : value_i;
          bcd_d   = '0;
          cnt_d   = CntBits'(VALUE_BITS);
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        bcd_d = {bcd_adj[4*NUM_DIGITS-2:0], sr_q[VALUE_BITS-1]};
        sr_d  = {sr_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          state_d = D_DONE;
        end
      end
      D_DONE: begin
        if (take_i) begin
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  // Control state with reset; the data registers need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    bcd_q <= bcd_d;
  end

  assign ready_o      = (state_q == D_IDLE);
  assign bcd_o        = bcd_q;
  assign conv_o.valid = (state_q == D_DONE);
  assign conv_o.neg   = neg_q;

endmodule

[rtl/itda_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: character emitter
// Walks the BCD digits from the top, drops leading zeros, puts a minus sign
// first for negative values and drives the output register.
// ----------------------------------------------------------------------------
module itda_emit #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Digits from the converter
  input  logic [4*NUM_DIGITS-1:0]         bcd_i,
  input  itda_pkg::itda_conv_t            conv_i,
  output logic                            take_o,
  output logic                            busy_o,
  // Output register
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [itda_pkg::CharBits-1:0]   out_char_o,
  output logic                            out_last_o
);
  import itda_pkg::*;

  localparam int unsigned CntBits = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {
    E_IDLE,
    E_SIGN,
    E_DIG
  } emit_state_e;

  emit_state_e             state_q, state_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic                    started_q, started_d;
  logic [4*NUM_DIGITS-1:0] dig_q, dig_d;
  logic                    ov_q, ov_d;
  logic [CharBits-1:0]     ch_q, ch_d;
  logic                    last_q, last_d;
  logic                    slot_free;
  logic [3:0]              top_dig;
  logic                    final_dig;

  assign slot_free = !ov_q || out_ready_i;
  assign top_dig   = dig_q[4*NUM_DIGITS-1 -: 4];
  assign final_dig = (cnt_q == CntBits'(1));
  assign take_o    = conv_i.valid && (state_q == E_IDLE);

  // One character (or one skipped leading zero) per cycle while the slot is free.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    dig_d     = dig_q;
    ch_d      = ch_q;
    last_d    = last_q;
    ov_d      = ov_q && !out_ready_i;
    unique case (state_q)
      E_IDLE: begin
        if (conv_i.valid) begin
          dig_d     = bcd_i;
          cnt_d     = CntBits'(NUM_DIGITS);
          started_d = 1'b0;
          state_d   = conv_i.neg ? E_SIGN : E_DIG;
        end
      end
      E_SIGN: begin
        if (slot_free) begin
          ch_d    = CharMinus;
          last_d  = 1'b0;
          ov_d    = 1'b1;
          state_d = E_DIG;
        end
      end
      E_DIG: begin
        if (slot_free) begin
          if (top_dig != 4'd0 || started_q || final_dig) begin
            ch_d      = CharZero | {4'b0000, top_dig};
            last_d    = final_dig;
            ov_d      = 1'b1;
            started_d = 1'b1;
          end
          dig_d = {dig_q[4*NUM_DIGITS-5:0], 4'b0000};
          cnt_d = cnt_q - 1'b1;
          if (final_dig) begin
            state_d = E_IDLE;
          end
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  // Control state with reset; the data registers need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= E_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != E_IDLE);
  assign out_valid_o = ov_q;
  assign out_char_o  = ch_q;
  assign out_last_o  = last_q;

endmodule

[rtl/integer_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to decimal ASCII unit
// Converts one integer word to its decimal text, one ASCII character per
// transfer, most significant digit first, with no leading zeros.
//
// Channel   Dir  tdata                tuser         tlast
// s_axis    in   value[31:0]          signed_mode   -
// m_axis    out  ascii_char[7:0]      -             last_char
//
// An input transfer starts a bit-serial conversion in the converter, which
// then hands the BCD digits to the emitter. The emitter walks every BCD digit
// (NUM_DIGITS, leading zeros included), after a minus sign if there is one.
// The next word converts while the previous text is emitted.
// Output stalls hold the emitter; reset returns both units to idle.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [itda_pkg::ValueFieldBits-1:0] s_axis_tdata_i, // [31:0] value
  input  logic                          s_axis_tuser_i,  // [0] signed_mode
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [itda_pkg::CharBits-1:0] m_axis_tdata_o,  // [7:0] ascii_char
  output logic                          m_axis_tlast_o   // last_char
);
  import itda_pkg::*;

  // Decimal digits of 2^VALUE_BITS - 1 (log10(2) to five places).
  localparam int unsigned NumDigits = (VALUE_BITS * 30103) / 100000 + 1;

  logic [VALUE_BITS-1:0]  value_word;
  logic                   dab_ready;
  logic [4*NumDigits-1:0] bcd;
  itda_conv_t             conv;
  logic                   take;
  logic                   emit_busy;

  // Only the low VALUE_BITS bits of the field count.
  assign value_word      = VALUE_BITS'(s_axis_tdata_i);
  assign s_axis_tready_o = dab_ready;

  itda_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NumDigits)
  ) u_dabble (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (s_axis_tvalid_i),
    .value_i       (value_word),
    .signed_mode_i (s_axis_tuser_i),
    .ready_o       (dab_ready),
    .bcd_o         (bcd),
    .conv_o        (conv),
    .take_i        (take)
  );

  itda_emit #(
    .NUM_DIGITS (NumDigits)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bcd_i       (bcd),
    .conv_i      (conv),
    .take_o      (take),
    .busy_o      (emit_busy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // An accepted word keeps the converter busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("converter took a word but did not go busy");

  // A handoff always starts the emitter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> emit_busy)
    else $error("emitter did not start after a handoff");

  // A minus sign is never the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o == CharMinus)) |-> !m_axis_tlast_o)
    else $error("minus sign marked as last character");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the integer to decimal ASCII unit
// Sends 32-bit words in both signed and unsigned mode. It predicts the
// decimal text of each accepted word and compares every output character and
// its last flag against the oldest predicted character. Both stream sides
// idle at random, and the receiver holds off once for a long stretch so that
// the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import itda_pkg::*;

  // One predicted output character with its end-of-text flag.
  typedef struct packed {
    logic [CharBits-1:0] ascii_char;
    logic                last_char;
  } dec_char_t;

  // Holds the decimal text predicted for every accepted word, in order.
  class decimal_text_board;
    dec_char_t pending_chars[$];
    int        failures;

    function new();
      failures = 0;
    endfunction

    // Predicts the text of one accepted word and queues its characters.
    function void add_word(logic [ValueFieldBits-1:0] value, logic signed_mode);
      logic                      neg;
      logic [ValueFieldBits-1:0] mag;
      logic [3:0]                digits[$];
      dec_char_t                 ch;
      neg = signed_mode && value[ValueFieldBits-1];
      mag = neg ? (~value + 1'b1) : value;
      // Collect the digits least significant first; zero still gives one.
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        ch.ascii_char = CharMinus;
        ch.last_char  = 1'b0;
        pending_chars.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.ascii_char = CharZero + CharBits'(digits[i]);
        ch.last_char  = (i == digits.size() - 1);
        pending_chars.push_back(ch);
      end
    endfunction

    // Compares one output transfer with the oldest predicted character.
    function void check_char(logic [CharBits-1:0] ascii_char, logic last_char);
      dec_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character 0x%02h (last %0b)", ascii_char, last_char);
        failures++;
        return;
      end
      want = pending_chars.pop_front();
      if (ascii_char !== want.ascii_char) begin
        $error("ascii_char: expected 0x%02h, got 0x%02h", want.ascii_char, ascii_char);
        failures++;
      end
      if (last_char !== want.last_char) begin
        $error("last_char: expected %0b, got %0b", want.last_char, last_char);
        failures++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  logic [ValueFieldBits-1:0] s_axis_tdata_i;
  logic                      s_axis_tuser_i;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  logic [CharBits-1:0]       m_axis_tdata_o;
  logic                      m_axis_tlast_o;

  decimal_text_board board = new();

  // Sender idling: 0 gives back-to-back words, 1 gives random gaps.
  int  send_gap_mode;
  // Receiver idling: when set, the receiver takes every character at once.
  bit  rx_calm;
  // Each increment asks the receiver for one long hold-off.
  int  hold_requests;

  integer_to_decimal_ascii_unit #(
    .VALUE_BITS(32)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Random word, drawn from shapes that exercise digit counts and signs.
  function automatic logic [ValueFieldBits-1:0] pick_value();
    logic [ValueFieldBits-1:0] p;
    int                        k;
    unique case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 99);
      2: begin
        // A power of ten, or one to either side of it.
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      3: return 32'hFFFF_FFFF - $urandom_range(0, 20);
      4: return 32'h8000_0000 ^ $urandom_range(0, 20);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Offers one word and returns at the falling edge after its transfer.
  task automatic send_word(logic [ValueFieldBits-1:0] value, logic signed_mode);
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= signed_mode;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.add_word(value, signed_mode);
    @(negedge clk_i);
  endtask

  // Optional idle gap after a transfer, with junk on the data lines.
  task automatic send_gap();
    int n;
    n = (send_gap_mode == 0) ? 0 : pick_gap();
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      s_axis_tuser_i  <= 1'($urandom);
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      send_word(pick_value(), 1'($urandom));
      send_gap();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_cnt;
    int hold_seen;
    hold_cnt  = 0;
    hold_seen = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_cnt  = 400;
      end else if (hold_cnt == 0 && !rx_calm && $urandom_range(0, 99) < 20) begin
        hold_cnt = pick_gap();
      end
      if (hold_cnt > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_cnt--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Output monitor: every character transfer is checked.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_char(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Main sequence.
  initial begin
    send_gap_mode   = 1;
    rx_calm         = 1'b0;
    hold_requests   = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words: zero, digit-count edges, sign edges, both modes.
    send_word(32'd0, 1'b0);           send_gap();
    send_word(32'd0, 1'b1);           send_gap();
    send_word(32'd1, 1'b1);           send_gap();
    send_word(32'd9, 1'b0);           send_gap();
    send_word(32'd10, 1'b1);          send_gap();
    send_word(32'd99, 1'b0);          send_gap();
    send_word(32'd100, 1'b0);         send_gap();
    send_word(32'd999_999_999, 1'b0); send_gap();
    send_word(32'd1_000_000_000, 1'b1); send_gap();
    send_word(32'd4_000_000_000, 1'b0); send_gap();
    send_word(32'hFFFF_FFFF, 1'b0);   send_gap();
    send_word(32'hFFFF_FFFF, 1'b1);   send_gap();
    send_word(32'h8000_0000, 1'b1);   send_gap();
    send_word(32'h8000_0000, 1'b0);   send_gap();
    send_word(32'h7FFF_FFFF, 1'b1);   send_gap();
    send_word(32'h7FFF_FFFF, 1'b0);   send_gap();
    send_word(32'hFFFF_FFF6, 1'b1);   send_gap();
    send_word(32'hAAAA_AAAA, 1'b1);   send_gap();
    send_word(32'hAAAA_AAAA, 1'b0);   send_gap();
    send_word(32'h5555_5555, 1'b1);   send_gap();
    send_word(32'h5555_5555, 1'b0);   send_gap();
    send_word(32'd12345, 1'b1);       send_gap();

    // Random words with idling on both sides.
    send_random(120);

    // Back-to-back words while the receiver holds off for a long stretch.
    send_gap_mode = 0;
    hold_requests++;
    send_random(30);

    // A stretch with no idling at all.
    rx_calm = 1'b1;
    send_random(40);

    // Random idling again to close.
    rx_calm       = 1'b0;
    send_gap_mode = 1;
    send_random(100);
    s_axis_tvalid_i <= 1'b0;

    // Drain, then allow time for any stray output.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/itda_pkg.sv
rtl/itda_dabble.sv
rtl/itda_emit.sv
rtl/integer_to_decimal_ascii_unit.sv
sim/tb_top.sv
